// ===== design/c3t_pkg.sv =====
package c3t_pkg;

    localparam int KERNEL_SIZE      = 3;
    localparam int KERNEL_TAPS      = KERNEL_SIZE * KERNEL_SIZE;
    localparam int DEF_IMAGE_WIDTH  = 8;
    localparam int DEF_IMAGE_HEIGHT = 8;
    localparam int DEF_FILTER_COUNT = 4;
    localparam int MAX_FILTERS      = 4;
    localparam int DATA_W           = 16;
    localparam int PROD_W           = 32;
    localparam int ACC_W            = 36;
    localparam int TANH_N           = 256;
    localparam int TANH_IDX_W       = $clog2(TANH_N);
    // acc is Q12.24; the table spans [-4,4) so the index is (acc + 4.0) >> (27 - idx bits)
    localparam int TANH_SHIFT       = 27 - TANH_IDX_W;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef logic signed [DATA_W-1:0] tanh_lut_t [TANH_N];

    // shift-subtract quotient, truncating toward zero; table math only
    function automatic longint cdiv(longint dividend, longint divisor);
        longint mag;
        longint rem;
        longint quo;
        mag = (dividend < 0) ? -dividend : dividend;
        rem = 0;
        quo = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((mag >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= divisor)
            begin
                rem = rem - divisor;
                quo = quo | 64'sd1;
            end
        end
        return (dividend < 0) ? -quo : quo;
    endfunction

    function automatic logic signed [DATA_W-1:0] tanh_entry(int idx);
        longint m;
        longint am;
        longint z;
        longint term;
        longint sum;
        longint e;
        longint num;
        longint den;
        longint q;
        longint kk;
        bit     neg;
        m   = 2 * longint'(idx) + 1 - TANH_N;
        neg = (m < 0);
        am  = neg ? -m : m;
        z   = (am <<< 30) >>> (TANH_IDX_W + 1);
        term = 64'sd1 <<< 30;
        sum  = 64'sd1 <<< 30;
        for (int k = 1; k <= 12; k++) begin
            kk   = longint'(k);
            term = cdiv((term * z) >>> 30, kk);
            sum  = ((k & 1) == 1) ? sum - term : sum + term;
        end
        e = sum;
        for (int k = 0; k < 4; k++) begin
            e = (e * e + (64'sd1 <<< 29)) >>> 30;
        end
        num = ((64'sd1 <<< 30) - e) * 16384;
        den = (64'sd1 <<< 30) + e;
        q   = cdiv(num + (den >>> 1), den);
        return neg ? DATA_W'(-q) : DATA_W'(q);
    endfunction

    function automatic tanh_lut_t tanh_build();
        tanh_lut_t lut;
        for (int i = 0; i < TANH_N; i++) begin
            lut[i] = tanh_entry(i);
        end
        return lut;
    endfunction

    localparam tanh_lut_t TANH_LUT = tanh_build();

endpackage

// ===== design/conv3x3_tanh_layer.sv =====
// channel  | dir | tdata (low bit up)                          | tuser | notes
// s_axis   | in  | index[5:0], value[21:6], pad to 24          | op    | weight, bias or pixel
// m_axis   | out | out_row, out_col, filter_zero..three, 72b   | -     | one per full window
//
// One transfer per cycle in while tready is high; each pixel completing a 3x3
// window position gives one result transfer (products, row sums, total, tanh).
// Rate is set by the valid-chained pipeline: any stage moves when the one
// ahead is empty or moving, so stalls only back up once all stages fill.
// rst_n clears the pipeline valids and the row and column counters; weights,
// biases and the window line are data only.
module conv3x3_tanh_layer #(
    parameter int IMAGE_WIDTH  = c3t_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = c3t_pkg::DEF_IMAGE_HEIGHT,
    parameter int FILTER_COUNT = c3t_pkg::DEF_FILTER_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // index[5:0], value[21:6], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // out_row[2:0], out_col[5:3], filter_zero[21:6],
                                        // filter_one[37:22], filter_two[53:38],
                                        // filter_three[69:54], zero pad
);
    import c3t_pkg::*;

    localparam int CW     = $clog2(IMAGE_WIDTH);
    localparam int RW     = $clog2(IMAGE_HEIGHT);
    localparam int NW     = FILTER_COUNT * KERNEL_TAPS;
    localparam int LINE_N = (KERNEL_SIZE - 1) * IMAGE_WIDTH;
    localparam int WIW    = $clog2(NW);
    localparam int BIW    = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;

    // input fields
    op_t                      op;
    logic [5:0]               index;
    logic signed [DATA_W-1:0] value;

    assign op    = op_t'(s_axis_tuser);
    assign index = s_axis_tdata[5:0];
    assign value = s_axis_tdata[21:6];

    // pipeline handshake: a stage loads when it is empty or the next one loads
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic ld1, ld2, ld3, ldo;
    logic s_fire, pix_fire, hit;

    assign ldo = !vo_reg || m_axis_tready;
    assign ld3 = !v3_reg || ldo;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign s_axis_tready = ld1;
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign pix_fire = s_fire && (op == OP_PIXEL);

    // coefficient stores
    logic signed [DATA_W-1:0] weight_reg [NW];
    logic signed [DATA_W-1:0] bias_reg   [FILTER_COUNT];

    always_ff @(posedge clk)
    begin
        if (s_fire && op == OP_WEIGHT && 32'(index) < NW)
        begin
            weight_reg[index[WIW-1:0]] <= value;
        end
        if (s_fire && op == OP_BIAS && 32'(index) < FILTER_COUNT)
        begin
            bias_reg[index[BIW-1:0]] <= value;
        end
    end

    // raster position
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_fire)
        begin
            if (32'(col_reg) == IMAGE_WIDTH - 1)
            begin
                col_next = '0;
                row_next = (32'(row_reg) == IMAGE_HEIGHT - 1) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign hit = pix_fire && (32'(row_reg) >= KERNEL_SIZE - 1)
                          && (32'(col_reg) >= KERNEL_SIZE - 1);

    // line delay: tap W-1 is the same column one row up, 2W-1 two rows up
    logic signed [DATA_W-1:0] line_reg [LINE_N];

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            line_reg[0] <= value;
            for (int i = 1; i < LINE_N; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    logic signed [DATA_W-1:0] colv [KERNEL_SIZE];

    always_comb
    begin
        for (int ky = 0; ky < KERNEL_SIZE - 1; ky++)
        begin
            colv[ky] = line_reg[(KERNEL_SIZE - 1 - ky) * IMAGE_WIDTH - 1];
        end
        colv[KERNEL_SIZE-1] = value;
    end

    // window: one row of cells per kernel row, newest column at kx = 2
    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] tap  [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0] prod [KERNEL_SIZE][KERNEL_SIZE][FILTER_COUNT];

    assign ctl.shift = pix_fire;
    assign ctl.load  = ld1;

    for (genvar ky = 0; ky < KERNEL_SIZE; ky++)
    begin : g_row
        for (genvar kx = 0; kx < KERNEL_SIZE; kx++)
        begin : g_col
            logic signed [DATA_W-1:0] w_cell [FILTER_COUNT];
            logic signed [DATA_W-1:0] d_cell;
            logic signed [PROD_W-1:0] p_cell [FILTER_COUNT];

            for (genvar f = 0; f < FILTER_COUNT; f++)
            begin : g_w
                assign w_cell[f] = weight_reg[f*KERNEL_TAPS + ky*KERNEL_SIZE + kx];
                assign prod[ky][kx][f] = p_cell[f];
            end

            if (kx == KERNEL_SIZE - 1)
            begin : g_new
                assign d_cell = colv[ky];
            end
            else
            begin : g_old
                assign d_cell = tap[ky][kx+1];
            end

            c3t_cell #(
                .FILTER_COUNT (FILTER_COUNT)
            ) u_cell (
                .clk    (clk),
                .ctl    (ctl),
                .din    (d_cell),
                .weight (w_cell),
                .dout   (tap[ky][kx]),
                .prod   (p_cell)
            );
        end
    end

    // stage 1 side data: bias in Q12.24 and position
    logic signed [ACC_W-1:0] bias1_reg [FILTER_COUNT];
    logic [2:0] row1_reg, col1_reg, row2_reg, col2_reg, row3_reg, col3_reg;
    logic [2:0] rowo_reg, colo_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            for (int f = 0; f < FILTER_COUNT; f++)
            begin
                bias1_reg[f] <= ACC_W'(bias_reg[f]) <<< 12;
            end
            row1_reg <= 3'(32'(row_reg) - (KERNEL_SIZE - 1));
            col1_reg <= 3'(32'(col_reg) - (KERNEL_SIZE - 1));
        end
    end

    // stage 2: one sum per kernel row, bias folded into the first
    logic signed [ACC_W-1:0] rsum_reg [FILTER_COUNT][KERNEL_SIZE];
    logic signed [ACC_W-1:0] rsum_next [FILTER_COUNT][KERNEL_SIZE];

    always_comb
    begin
        for (int f = 0; f < FILTER_COUNT; f++)
        begin
            for (int ky = 0; ky < KERNEL_SIZE; ky++)
            begin
                rsum_next[f][ky] = (ky == 0) ? bias1_reg[f] : '0;
                for (int kx = 0; kx < KERNEL_SIZE; kx++)
                begin
                    rsum_next[f][ky] = rsum_next[f][ky] + ACC_W'(prod[ky][kx][f]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            rsum_reg <= rsum_next;
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
        end
    end

    // stage 3: full accumulator
    logic signed [ACC_W-1:0] acc_reg  [FILTER_COUNT];
    logic signed [ACC_W-1:0] acc_next [FILTER_COUNT];

    always_comb
    begin
        for (int f = 0; f < FILTER_COUNT; f++)
        begin
            acc_next[f] = '0;
            for (int ky = 0; ky < KERNEL_SIZE; ky++)
            begin
                acc_next[f] = acc_next[f] + rsum_reg[f][ky];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            acc_reg  <= acc_next;
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
        end
    end

    // output stage: saturate to [-4,4), index the table
    logic signed [ACC_W-1:0]  t_val [FILTER_COUNT];
    logic [TANH_IDX_W-1:0]    tidx  [FILTER_COUNT];
    logic signed [DATA_W-1:0] y_next [MAX_FILTERS];
    logic signed [DATA_W-1:0] y_reg  [MAX_FILTERS];

    always_comb
    begin
        for (int f = 0; f < MAX_FILTERS; f++)
        begin
            y_next[f] = '0;
        end
        for (int f = 0; f < FILTER_COUNT; f++)
        begin
            t_val[f] = acc_reg[f] + (ACC_W'(1) <<< 26);
            if (t_val[f] < 0)
            begin
                tidx[f] = '0;
            end
            else if (t_val[f] >= (ACC_W'(1) <<< 27))
            begin
                tidx[f] = '1;
            end
            else
            begin
                tidx[f] = t_val[f][TANH_SHIFT +: TANH_IDX_W];
            end
            y_next[f] = TANH_LUT[tidx[f]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ldo)
        begin
            y_reg    <= y_next;
            rowo_reg <= row3_reg;
            colo_reg <= col3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= hit;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ldo) vo_reg <= v3_reg;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {2'b00, y_reg[3], y_reg[2], y_reg[1], y_reg[0],
                            colo_reg, rowo_reg};

    // weight and bias loads never start a result
    a_cfg_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && op != OP_PIXEL) |=> !v1_reg)
        else $error("coefficient load produced a result");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < IMAGE_WIDTH && 32'(row_reg) < IMAGE_HEIGHT)
        else $error("raster counter out of range");

    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !ldo) |=> v3_reg)
        else $error("stage 3 item dropped while output stalled");

    a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
        vo_reg |-> (32'(rowo_reg) <= IMAGE_HEIGHT - KERNEL_SIZE || IMAGE_HEIGHT > 10))
        else $error("result row beyond last window");

endmodule

// ===== design/c3t_cell.sv =====
module c3t_cell #(
    parameter int FILTER_COUNT = c3t_pkg::DEF_FILTER_COUNT
) (
    input  logic                                 clk,
    input  c3t_pkg::cell_ctl_t                   ctl,
    input  logic signed [c3t_pkg::DATA_W-1:0]    din,
    input  logic signed [c3t_pkg::DATA_W-1:0]    weight [FILTER_COUNT],
    output logic signed [c3t_pkg::DATA_W-1:0]    dout,
    output logic signed [c3t_pkg::PROD_W-1:0]    prod [FILTER_COUNT]
);
    import c3t_pkg::*;

    logic signed [DATA_W-1:0] tap_reg;
    logic signed [DATA_W-1:0] tap_next;
    logic signed [PROD_W-1:0] prod_reg [FILTER_COUNT];

    // tap shifts in from the newer neighbor on a pixel
    assign tap_next = ctl.shift ? din : tap_reg;

    always_ff @(posedge clk)
    begin
        tap_reg <= tap_next;
        if (ctl.load)
        begin
            for (int f = 0; f < FILTER_COUNT; f++)
            begin
                prod_reg[f] <= PROD_W'(tap_next * weight[f]);
            end
        end
    end

    assign dout = tap_reg;
    assign prod = prod_reg;

endmodule

// ===== test/conv3x3_tanh_layer_chk.sv =====
module conv3x3_tanh_layer_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          window_count
);
    import c3t_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] f0;
        logic signed [15:0] f1;
        logic signed [15:0] f2;
        logic signed [15:0] f3;
    } window_out_t;

    logic signed [15:0] kernel_w [36];
    logic signed [15:0] bias_w [4];
    logic signed [15:0] line_buf [2][8];
    logic signed [15:0] win [3][3];
    int                 cur_row;
    int                 cur_col;
    window_out_t        expected_q [$];

    // index = clamp(((acc + 4.0) * 256) >> 27), entry from the tanh table formula
    function automatic logic signed [15:0] act_tanh(longint acc);
        longint t;
        longint idx;
        longint m;
        longint am;
        longint z;
        longint term;
        longint sum;
        longint e;
        longint num;
        longint den;
        longint q;
        t = acc + (longint'(4) <<< 24);
        if (t < 0)
            idx = 0;
        else
            idx = (t * 256) >>> 27;
        if (idx > 255)
            idx = 255;
        m = 2 * idx + 1 - 256;
        am = (m < 0) ? -m : m;
        z = (am <<< 30) / 512;
        term = longint'(1) <<< 30;
        sum = term;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * z) >>> 30) / k;
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        e = sum;
        for (int k = 0; k < 4; k++)
            e = (e * e + (longint'(1) <<< 29)) >>> 30;
        num = ((longint'(1) <<< 30) - e) * 16384;
        den = (longint'(1) <<< 30) + e;
        q = (num + den / 2) / den;
        return (m < 0) ? 16'(-q) : 16'(q);
    endfunction

    task automatic absorb_transfer(logic [1:0] op, logic [5:0] idx, logic signed [15:0] v);
        logic signed [15:0] colv [3];
        logic signed [15:0] outs [4];
        window_out_t        r;
        longint             acc;
        if (op == OP_WEIGHT)
        begin
            if (idx < 36)
                kernel_w[idx] = v;
        end
        else if (op == OP_BIAS)
        begin
            if (idx < 4)
                bias_w[idx] = v;
        end
        else if (op == OP_PIXEL)
        begin
            colv[0] = line_buf[0][cur_col];
            colv[1] = line_buf[1][cur_col];
            colv[2] = v;
            for (int y = 0; y < 3; y++)
            begin
                win[y][0] = win[y][1];
                win[y][1] = win[y][2];
                win[y][2] = colv[y];
            end
            line_buf[0][cur_col] = line_buf[1][cur_col];
            line_buf[1][cur_col] = v;
            if (cur_row >= 2 && cur_col >= 2)
            begin
                for (int f = 0; f < 4; f++)
                begin
                    acc = longint'(bias_w[f]) * 4096;
                    for (int i = 0; i < 9; i++)
                        acc += longint'(kernel_w[f*9+i]) * longint'(win[i/3][i%3]);
                    outs[f] = act_tanh(acc);
                end
                r.row = 3'(cur_row - 2);
                r.col = 3'(cur_col - 2);
                r.f0 = outs[0];
                r.f1 = outs[1];
                r.f2 = outs[2];
                r.f3 = outs[3];
                expected_q.push_back(r);
            end
            cur_col++;
            if (cur_col == 8)
            begin
                cur_col = 0;
                cur_row = (cur_row + 1) % 8;
            end
        end
    endtask

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            fail_count++;
            $display("%0t %s: expected %0d, got %0d", $realtime, name, exp_v, act_v);
        end
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        window_out_t got;
        window_out_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            window_count <= 0;
            cur_row = 0;
            cur_col = 0;
            for (int i = 0; i < 16; i++)
                line_buf[i/8][i%8] = '0;
            for (int i = 0; i < 9; i++)
                win[i/3][i%3] = '0;
            expected_q.delete();
        end
        else
        begin
            // result side first: a result can't stem from this same-edge input
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.row = m_axis_tdata[2:0];
                got.col = m_axis_tdata[5:3];
                got.f0 = m_axis_tdata[21:6];
                got.f1 = m_axis_tdata[37:22];
                got.f2 = m_axis_tdata[53:38];
                got.f3 = m_axis_tdata[69:54];
                window_count <= window_count + 1;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result transfer %h", $realtime, m_axis_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("out_row", want.row, got.row);
                    compare_field("out_col", want.col, got.col);
                    compare_field("filter_zero", want.f0, got.f0);
                    compare_field("filter_one", want.f1, got.f1);
                    compare_field("filter_two", want.f2, got.f2);
                    compare_field("filter_three", want.f3, got.f3);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_transfer(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[21:6]);
        end
    end

endmodule

// ===== test/conv3x3_tanh_layer_tb.sv =====
module conv3x3_tanh_layer_tb;
    import c3t_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // index[5:0], value[21:6], zero pad
    logic [1:0]  s_axis_tuser;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // out_row, out_col, filter_zero..filter_three, pad
    int          fail_count;
    int          pending;
    int          window_count;
    int          idle_cycles;
    int          sent;
    bit          steady;          // no idling while set
    bit          timed_out;

    conv3x3_tanh_layer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    conv3x3_tanh_layer_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .window_count  (window_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result side stalls about 15% of cycles, except during the steady stretch
    always @(negedge clk)
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 15);

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results pending", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one input transfer; random idle cycles before it unless steady
    task automatic push_item(op_t op, logic [5:0] idx, logic [15:0] v);
        while (!steady && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, v, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic load_kernels(bit extreme);
        for (int i = 0; i < 36; i++)
            push_item(OP_WEIGHT, 6'(i), extreme ? ((i % 2) ? 16'h8000 : 16'h7FFF)
                                                : 16'($urandom_range(1200) - 600));
        for (int f = 0; f < 4; f++)
            push_item(OP_BIAS, 6'(f), 16'($urandom));
    endtask

    // wide spread on some pixels pushes tanh into both saturated ends
    task automatic send_frame(int max_pix);
        for (int p = 0; p < 64; p++)
            push_item(OP_PIXEL, 6'($urandom), ($urandom_range(3) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(max_pix * 2) - max_pix));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_NONE;
        m_axis_tready <= 1'b0;
        idle_cycles <= 0;
        sent = 0;
        steady = 1'b0;
        timed_out = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: full-scale weights, extreme biases, out-of-range indexes, unused op
        for (int i = 0; i < 36; i++)
            push_item(OP_WEIGHT, 6'(i), (i % 3 == 0) ? 16'h7FFF : 16'h8000);
        push_item(OP_BIAS, 6'd0, 16'h7FFF);
        push_item(OP_BIAS, 6'd1, 16'h8000);
        push_item(OP_BIAS, 6'd2, 16'h0000);
        push_item(OP_BIAS, 6'd3, 16'hFFFF);
        push_item(OP_WEIGHT, 6'd63, 16'h1234);
        push_item(OP_WEIGHT, 6'd36, 16'hFFFF);
        push_item(OP_BIAS, 6'd4, 16'h5555);
        push_item(OP_BIAS, 6'd63, 16'hAAAA);
        push_item(OP_NONE, 6'h3F, 16'hFFFF);
        push_item(OP_NONE, 6'h00, 16'h0000);
        for (int p = 0; p < 20; p++)
            push_item(OP_PIXEL, 6'(p), (p % 2) ? 16'h8000 : 16'h7FFF);

        // random: frames with reloads in between; kernels may change mid-frame
        while (sent < 420)
        begin
            steady = (sent > 250 && sent < 340);
            case ($urandom_range(9))
                0: load_kernels(1'b1);
                1, 2: load_kernels(1'b0);
                3: push_item(op_t'($urandom_range(3)), 6'($urandom), 16'($urandom));
                default: send_frame(($urandom_range(1)) ? 32767 : 2048);
            endcase
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d input transfers, %0d windows checked (extreme and random kernels)",
                 sent, window_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
